### rtl/cts_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cts_pkg
// Shared types, widths and helpers for the cosine Taylor series unit.
// ============================================================================
package cts_pkg;

    // Default and largest supported number of series terms.
    localparam int CTS_MAX_TERMS = 16;

    // Field widths of the request and result.
    localparam int NT_W   = 5;   // term count field
    localparam int X_W    = 16;  // angle, Q2.13
    localparam int RES_W  = 32;  // sum, Q15.16

    // Datapath widths.
    localparam int XABS_W = X_W + 1;          // magnitude of the angle
    localparam int XSQ_W  = 31;               // x squared, Q.26, at most 2^30
    localparam int M_W    = 35;               // term magnitude, Q.30
    localparam int MLO_W  = 18;               // low slice of the term for the multiplier
    localparam int MHI_W  = M_W - MLO_W;      // high slice of the term
    localparam int MUL_W  = MLO_W + XSQ_W;    // partial product width
    localparam int PROD_W = M_W + XSQ_W;      // full product width
    localparam int SHR_Q  = 26;               // Q.56 back to Q.30
    localparam int DVD_W  = PROD_W - SHR_Q;   // dividend width
    localparam int DEN_W  = 10;               // (2k-1)(2k) for k up to 15
    localparam int BCNT_W = $clog2(DVD_W);
    localparam int SUM_W  = 40;               // running sum, signed Q.30
    localparam int FRAC_DROP = 14;            // Q.30 to Q.16
    localparam int Q16_W  = SUM_W - FRAC_DROP;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV_INIT,
        ST_DIV,
        ST_ACCUM,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;      // take a new request
        logic             mul_lo;    // low partial product
        logic             mul_hi;    // high partial product, accumulated
        logic             div_init;  // start the serial division
        logic             div_step;  // one quotient bit
        logic             accum;     // fold the new term into the sum
        logic             subtract;  // odd term index: subtract
        logic             out_load;  // capture the result
        logic [NT_W-1:0]  term_idx;  // current term index k
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;  // final quotient bit this cycle
    } sts_t;

    // Divisor of term k: (2k-1)(2k).
    function automatic logic [DEN_W-1:0] term_den(input logic [NT_W-1:0] k);
        logic [DEN_W-1:0] a;
        a = DEN_W'({k, 1'b0});
        return a * (a - DEN_W'(1));
    endfunction

endpackage

### rtl/cts_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// cts_ctrl
// Sequencer for the series: walks each term through multiply, divide and
// accumulate, and owns the request and result handshakes.
// ============================================================================
module cts_ctrl
    import cts_pkg::*;
#(
    parameter int MAX_TERMS = CTS_MAX_TERMS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [NT_W-1:0] s_num_terms,
    output logic            m_valid,
    input  logic            m_ready,
    output cmd_t            cmd,
    input  sts_t            sts
);

    localparam int N_W = $clog2(MAX_TERMS + 1);

    state_t         state_reg, state_next;
    logic [N_W-1:0] n_reg, n_next;
    logic [N_W-1:0] k_reg, k_next;
    logic           m_valid_reg, m_valid_next;
    logic           out_free;
    logic           accept;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_CHECK;
            ST_CHECK:    state_next = (k_reg >= n_reg) ? ST_FINISH : ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:      if (sts.div_last) state_next = ST_ACCUM;
            ST_ACCUM:    state_next = ST_CHECK;
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        cmd          = '0;
        cmd.term_idx = NT_W'(k_reg);
        cmd.subtract = k_reg[0];
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_MUL_LO:   cmd.mul_lo   = 1'b1;
            ST_MUL_HI:   cmd.mul_hi   = 1'b1;
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_ACCUM:    cmd.accum    = 1'b1;
            ST_FINISH:   cmd.out_load = out_free;
            default: ;
        endcase
    end

    // Term counters and the result valid flag.
    always_comb begin
        n_next = n_reg;
        k_next = k_reg;
        if (accept) begin
            n_next = (s_num_terms > NT_W'(MAX_TERMS)) ? N_W'(MAX_TERMS)
                                                       : N_W'(s_num_terms);
            k_next = N_W'(1);
        end else if (cmd.accum) begin
            k_next = k_reg + N_W'(1);
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### rtl/cts_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// cts_datapath
// Arithmetic for the series: x squared, a shared split multiplier, a
// restoring bit-serial divider, the running sum and the output stage.
// ============================================================================
module cts_datapath
    import cts_pkg::*;
(
    input  logic                    aclk,
    input  logic signed [X_W-1:0]   s_x_value,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    output logic signed [RES_W-1:0] m_series_sum,
    output logic                    m_saturated
);

    logic [XSQ_W-1:0]        xsq_reg, xsq_next;
    logic [M_W-1:0]          m_reg, m_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [DVD_W-1:0]        dvd_reg, dvd_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [BCNT_W-1:0]       bcnt_reg, bcnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [RES_W-1:0]        res_reg, res_next;
    logic                    sat_reg, sat_next;

    logic [XABS_W-1:0] x_ext, x_abs;
    logic [MLO_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_p;
    logic [DEN_W:0]    trial;
    logic              qbit;
    logic              neg;
    logic [SUM_W-1:0]  mag;
    logic [Q16_W-1:0]  q16;
    logic [RES_W:0]    q16_ext;
    logic              clip;

    // Angle magnitude and its square, taken when a request arrives.
    assign x_ext = {s_x_value[X_W-1], s_x_value};
    assign x_abs = s_x_value[X_W-1] ? (XABS_W'(0) - x_ext) : x_ext;

    // One shared multiplier covers the term in two slices.
    assign mul_a = cmd.mul_hi ? MLO_W'(m_reg[M_W-1:MLO_W]) : m_reg[MLO_W-1:0];
    assign mul_p = MUL_W'(mul_a) * MUL_W'(xsq_reg);

    // Restoring division step: one quotient bit per cycle.
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    assign sts.div_last = (bcnt_reg == BCNT_W'(DVD_W - 1));

    // Q.30 sum to saturated Q15.16, truncating toward zero.
    assign neg     = sum_reg[SUM_W-1];
    assign mag     = neg ? (SUM_W'(0) - SUM_W'(sum_reg)) : SUM_W'(sum_reg);
    assign q16     = mag[SUM_W-1:FRAC_DROP];
    assign q16_ext = (RES_W + 1)'(q16);
    assign clip    = neg ? (q16_ext > {2'b01, {(RES_W - 1){1'b0}}})
                         : (q16_ext > {2'b00, {(RES_W - 1){1'b1}}});

    always_comb begin
        xsq_next  = xsq_reg;
        m_next    = m_reg;
        prod_next = prod_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        bcnt_next = bcnt_reg;
        sum_next  = sum_reg;
        res_next  = res_reg;
        sat_next  = sat_reg;

        // New request: term and sum start at 1.0.
        if (cmd.load) begin
            xsq_next = XSQ_W'(x_abs) * XSQ_W'(x_abs);
            m_next   = M_W'(1) << 30;
            sum_next = SUM_W'(1) << 30;
        end

        // Product of the term and x squared.
        if (cmd.mul_lo) begin
            prod_next = PROD_W'(mul_p);
        end
        if (cmd.mul_hi) begin
            prod_next = prod_reg + (PROD_W'(mul_p) << MLO_W);
        end

        // Divider control.
        if (cmd.div_init) begin
            dvd_next  = prod_reg[PROD_W-1:SHR_Q];
            rem_next  = '0;
            den_next  = term_den(cmd.term_idx);
            bcnt_next = '0;
        end
        if (cmd.div_step) begin
            rem_next  = qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            dvd_next  = {dvd_reg[DVD_W-2:0], qbit};
            bcnt_next = bcnt_reg + BCNT_W'(1);
        end

        // Fold the new term into the sum with alternating sign.
        if (cmd.accum) begin
            m_next   = dvd_reg[M_W-1:0];
            sum_next = cmd.subtract ? (sum_reg - $signed(SUM_W'(dvd_reg)))
                                    : (sum_reg + $signed(SUM_W'(dvd_reg)));
        end

        // Output register.
        if (cmd.out_load) begin
            sat_next = clip;
            if (clip) begin
                res_next = neg ? {1'b1, {(RES_W - 1){1'b0}}} : {1'b0, {(RES_W - 1){1'b1}}};
            end else begin
                res_next = neg ? (RES_W'(0) - RES_W'(q16)) : RES_W'(q16);
            end
        end
    end

    always_ff @(posedge aclk) begin
        xsq_reg  <= xsq_next;
        m_reg    <= m_next;
        prod_reg <= prod_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        bcnt_reg <= bcnt_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
        sat_reg  <= sat_next;
    end

    assign m_series_sum = $signed(res_reg);
    assign m_saturated  = sat_reg;

endmodule

### rtl/cosine_taylor_series_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// cosine_taylor_series_unit
// Partial Taylor sum of cos x in fixed point, one request at a time.
// ============================================================================
// Usage:
// A request carries a term count (s_num_terms, counting the leading 1) and
// an angle in signed Q2.13 (s_x_value) on a valid/ready channel. The result
// comes back on the m_ channel as a signed Q15.16 sum with a saturation flag.
// Counts of zero or one give 1.0; counts above MAX_TERMS are clamped.
// Each further term passes a loop check, the split multiply (low, then high
// slice) on the shared multiplier, a divider setup, the bit-serial divide by
// (2k-1)(2k) and an accumulate step. One request is worked on at a time.
// A new request is taken as soon as the previous result sits in the output
// register, even while the receiver still stalls it. A finished result waits
// there until m_ready; the next one cannot leave the sequencer until then.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops
// m_valid; no stored data needs clearing.
// ============================================================================
module cosine_taylor_series_unit
    import cts_pkg::*;
#(
    parameter int MAX_TERMS = CTS_MAX_TERMS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [NT_W-1:0]         s_num_terms,
    input  logic signed [X_W-1:0]   s_x_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [RES_W-1:0] m_series_sum,
    output logic                    m_saturated
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    cts_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_num_terms (s_num_terms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    // Arithmetic.
    cts_datapath u_datapath (
        .aclk         (aclk),
        .s_x_value    (s_x_value),
        .cmd          (cmd),
        .sts          (sts),
        .m_series_sum (m_series_sum),
        .m_saturated  (m_saturated)
    );

`ifndef ASSERT_OFF
    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Once a request is taken the sequencer is busy the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // A single-term request returns exactly 1.0 once the sequencer has passed its check and finish states.
    a_single_term: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_num_terms <= 5'd1) && !m_valid
        |=> ##2 m_valid && (m_series_sum == 32'sh0001_0000) && !m_saturated)
        else $error("wrong result for one term");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Cosine Taylor series unit testbench
// Sends term count and angle requests on the s_ channel and checks every
// m_ result against a fixed-point model of the partial cosine series. A
// short table of corner cases comes first. Random requests follow, run
// under several sender and receiver idle patterns, and include one long
// receiver hold-off.
// ============================================================================
module testbench;
    import cts_pkg::*;

    localparam int  CLK_PERIOD     = 2;
    localparam int  RESET_CYCLES   = 8;
    localparam int  RANDOM_PER_PH  = 108;
    localparam int  HOLD_CYCLES    = 2000;
    localparam int  HOLD_AT        = 30;
    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 700;
    localparam int  REPORT_LIMIT   = 10;

    // One row of the directed table. An expected value is stored only when
    // known_result is set; the other rows go through the predictor.
    typedef struct packed {
        logic [NT_W-1:0]         terms;
        logic signed [X_W-1:0]   angle;
        logic                    known_result;
        logic signed [RES_W-1:0] sum;
        logic                    sat;
    } stim_row_t;

    // Expected result of one request, kept with the request for reporting.
    typedef struct packed {
        logic [NT_W-1:0]         terms;
        logic signed [X_W-1:0]   angle;
        logic signed [RES_W-1:0] sum;
        logic                    sat;
    } cos_result_t;

    localparam int NUM_DIRECTED = 21;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [NT_W-1:0]         s_num_terms;
    logic signed [X_W-1:0]   s_x_value;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [RES_W-1:0] m_series_sum;
    logic                    m_saturated;

    cos_result_t pending_sums[$];
    int          mismatch_count    = 0;
    int          accepted_requests = 0;
    int          send_idle_pct     = 0;
    int          recv_stall_pct    = 0;
    int          idle_cycles       = 0;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{5'd0,  16'sd0,      1'b1, 32'sd65536,   1'b0},
        '{5'd1,  -16'sd32768, 1'b1, 32'sd65536,   1'b0},
        '{5'd0,  16'sd32767,  1'b1, 32'sd65536,   1'b0},
        '{5'd31, 16'sd0,      1'b1, 32'sd65536,   1'b0},
        '{5'd16, 16'sd0,      1'b1, 32'sd65536,   1'b0},
        '{5'd2,  16'sd8192,   1'b1, 32'sd32768,   1'b0},
        '{5'd2,  -16'sd8192,  1'b1, 32'sd32768,   1'b0},
        '{5'd2,  16'sd16384,  1'b1, -32'sd65536,  1'b0},
        '{5'd2,  -16'sd32768, 1'b1, -32'sd458752, 1'b0},
        '{5'd16, -16'sd32768, 1'b0, 32'sd0,       1'b0},
        '{5'd16, 16'sd32767,  1'b0, 32'sd0,       1'b0},
        '{5'd17, 16'sd12345,  1'b0, 32'sd0,       1'b0},
        '{5'd31, -16'sd32768, 1'b0, 32'sd0,       1'b0},
        '{5'd15, -16'sd1,     1'b0, 32'sd0,       1'b0},
        '{5'd3,  16'sd8192,   1'b0, 32'sd0,       1'b0},
        '{5'd8,  16'sd25736,  1'b0, 32'sd0,       1'b0},
        '{5'd10, -16'sd12868, 1'b0, 32'sd0,       1'b0},
        '{5'd4,  16'sd1,      1'b0, 32'sd0,       1'b0},
        '{5'd16, 16'sd21845,  1'b0, 32'sd0,       1'b0},
        '{5'd16, -16'sd21846, 1'b0, 32'sd0,       1'b0},
        '{5'd5,  -16'sd16384, 1'b0, 32'sd0,       1'b0}
    };

    cosine_taylor_series_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_num_terms  (s_num_terms),
        .s_x_value    (s_x_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_series_sum (m_series_sum),
        .m_saturated  (m_saturated)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Partial cosine sum in Q.30: each term is the previous magnitude times
    // x squared, scaled back, and divided by (2k-1)(2k), with alternating sign.
    function automatic cos_result_t cos_partial_sum(input logic [NT_W-1:0] terms_in,
                                                    input logic signed [X_W-1:0] angle);
        cos_result_t      res;
        int               terms;
        int               angle_int;
        logic [63:0]      x_mag;
        logic [63:0]      x_sq;
        logic [127:0]     product;
        logic [63:0]      term_mag;
        logic signed [63:0] acc;
        logic [63:0]      acc_mag;
        logic [63:0]      q16;
        logic             negative;
        res.terms = terms_in;
        res.angle = angle;
        res.sat   = 1'b0;
        terms     = (int'(terms_in) > CTS_MAX_TERMS) ? CTS_MAX_TERMS : int'(terms_in);
        angle_int = int'(angle);
        x_mag     = 64'((angle_int < 0) ? -angle_int : angle_int);
        x_sq      = x_mag * x_mag;
        term_mag  = 64'd1 << 30;
        acc       = 64'sd1 <<< 30;
        for (int k = 1; k < terms; k++) begin
            product  = 128'(term_mag) * 128'(x_sq);
            term_mag = 64'((product >> 26) / 128'((2 * k - 1) * (2 * k)));
            if (k % 2 == 1) begin
                acc = acc - $signed(term_mag);
            end else begin
                acc = acc + $signed(term_mag);
            end
        end
        negative = acc < 0;
        acc_mag  = negative ? 64'(-acc) : 64'(acc);
        q16      = acc_mag >> 14;
        if (negative) begin
            if (q16 > 64'h8000_0000) begin
                q16     = 64'h8000_0000;
                res.sat = 1'b1;
            end
            res.sum = RES_W'(-q16);
        end else begin
            if (q16 > 64'h7FFF_FFFF) begin
                q16     = 64'h7FFF_FFFF;
                res.sat = 1'b1;
            end
            res.sum = RES_W'(q16);
        end
        return res;
    endfunction

    // Offer one request after a random idle gap and wait for its acceptance.
    // Returns at the falling edge after the accepting edge.
    task automatic send_request(input logic [NT_W-1:0] terms,
                                input logic signed [X_W-1:0] angle,
                                input bit known_result,
                                input cos_result_t known);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_num_terms <= terms;
        s_x_value   <= angle;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        accepted_requests++;
        if (known_result) begin
            pending_sums.push_back(known);
        end else begin
            pending_sums.push_back(cos_partial_sum(terms, angle));
        end
        @(negedge aclk);
    endtask

    // Receiver: random stalls per phase, plus one long hold-off early in the
    // random part so the unit fills up and stalls its input.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && accepted_requests >= HOLD_AT) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result checker: compare each result with the oldest expectation.
    always @(posedge aclk) begin
        cos_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_sums.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected result: sum=%0d sat=%0b",
                             m_series_sum, m_saturated);
                end
            end else begin
                want = pending_sums.pop_front();
                if (m_series_sum !== want.sum || m_saturated !== want.sat) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display({"mismatch n=%0d x=%0d: expected sum=%0d sat=%0b,",
                                  " got sum=%0d sat=%0b"},
                                 want.terms, want.angle, want.sum, want.sat,
                                 m_series_sum, m_saturated);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a request.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial begin
        cos_result_t known;
        logic [NT_W-1:0]       terms;
        logic signed [X_W-1:0] angle;
        int sel;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_num_terms = '0;
        s_x_value   = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed corners with no idling on either side.
        foreach (directed_rows[i]) begin
            known.terms = directed_rows[i].terms;
            known.angle = directed_rows[i].angle;
            known.sum   = directed_rows[i].sum;
            known.sat   = directed_rows[i].sat;
            send_request(directed_rows[i].terms, directed_rows[i].angle,
                         directed_rows[i].known_result, known);
        end

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (int i = 0; i < RANDOM_PER_PH; i++) begin
                // Mostly short series; long and clamped counts now and then.
                sel = $urandom_range(99);
                if (sel < 65) begin
                    terms = NT_W'($urandom_range(6));
                end else if (sel < 88) begin
                    terms = NT_W'($urandom_range(16, 7));
                end else begin
                    terms = NT_W'($urandom_range(31, 17));
                end
                sel = $urandom_range(99);
                case (sel % 4)
                    0: angle = (sel < 8) ? -16'sd32768 : X_W'($urandom_range(65535));
                    1: angle = (sel < 8) ? 16'sd32767  : X_W'($urandom_range(65535));
                    2: angle = (sel < 8) ? -16'sd1     : X_W'($urandom_range(65535));
                    default: angle = (sel < 8) ? 16'sd0 : X_W'($urandom_range(65535));
                endcase
                send_request(terms, angle, 1'b0, known);
            end
        end
        s_valid <= 1'b0;

        while (pending_sums.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_sums.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
